// ===== src/kcl_pkg.sv =====
// Shared types, codes and default-code tables for the keypad code lock.
`default_nettype none

package kcl_pkg;

    localparam int DIGIT_W   = 4;
    localparam int LEN_W     = 6;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int DEF_A_LEN = 9;
    localparam int DEF_B_LEN = 3;

    localparam logic [OP_W-1:0] OP_DIGIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd2;
    localparam logic [OP_W-1:0] OP_FUNC   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DIGIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DIGIT_W-1:0] key_value;
        logic               door_switch;
    } kcl_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                code_slot;
        logic [LEN_W-1:0]    entry_length;
    } kcl_out_t;

    // controller -> datapath
    typedef struct packed {
        logic                push;
        logic                walk_init;
        logic                walk;
        logic                walk_copy;
        logic                unlock_fin;
        logic                store_fin;
        logic                emit;
        logic [STATUS_W-1:0] status;
    } kcl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic walk_end;
        logic match_a;
        logic match_b;
    } kcl_sts_t;

    // factory code one: 9,8,7,...,1
    function automatic logic [DIGIT_W-1:0] default_a_digit(input logic [LEN_W-1:0] k);
        logic [DIGIT_W-1:0] d;
        d = '0;
        if (k < LEN_W'(DEF_A_LEN))
        begin
            d = DIGIT_W'(LEN_W'(DEF_A_LEN) - k);
        end
        return d;
    endfunction

    // factory code two: 1,2,3
    function automatic logic [DIGIT_W-1:0] default_b_digit(input logic [LEN_W-1:0] k);
        logic [DIGIT_W-1:0] d;
        d = '0;
        if (k < LEN_W'(DEF_B_LEN))
        begin
            d = DIGIT_W'(k + 1'b1);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/keypad_code_lock.sv =====
// Top level of the keypad code lock: controller and datapath.
//
//  channel  | ports                 | handshake             | beat
//  ---------+-----------------------+-----------------------+---------------------------
//  key in   | start, busy, item     | start && !busy        | op, key_value, door_switch
//  result   | done, result          | done (one cycle)      | status, code_slot, length
//
//  Digit, ignored and function keys: result in the cycle after the beat; busy stays low.
//  Unlock and store: busy while the compare or copy walks one digit per cycle through the
//  entry and code memories; the result appears in the cycle in which busy falls.
//  Reset is asynchronous, active low; codes return to their factory values.
//  The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none

module keypad_code_lock #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire kcl_pkg::kcl_in_t item,
    output logic                  busy,
    output logic                  done,
    output kcl_pkg::kcl_out_t     result
);
    import kcl_pkg::*;

    kcl_cmd_t cmd;
    kcl_sts_t sts;

    kcl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    kcl_dp #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_value (item.key_value),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/kcl_dp.sv =====
// Datapath of the keypad code lock: entry and code memories, digit walk, result register.
`default_nettype none

module kcl_dp #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [kcl_pkg::DIGIT_W-1:0]    key_value,
    input  wire kcl_pkg::kcl_cmd_t              cmd,
    output kcl_pkg::kcl_sts_t                   sts,
    output kcl_pkg::kcl_out_t                   result
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
    localparam int IDX_W = $clog2(MAX_CODE_LEN);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_CODE_LEN);
    localparam logic [CNT_W-1:0] A_RST_LEN =
        CNT_W'((MAX_CODE_LEN < DEF_A_LEN) ? MAX_CODE_LEN : DEF_A_LEN);
    localparam logic [CNT_W-1:0] B_RST_LEN =
        CNT_W'((MAX_CODE_LEN < DEF_B_LEN) ? MAX_CODE_LEN : DEF_B_LEN);

    logic [DIGIT_W-1:0] entry_mem [MAX_CODE_LEN];
    logic [DIGIT_W-1:0] code_a_mem [MAX_CODE_LEN];
    logic [DIGIT_W-1:0] code_b_mem [MAX_CODE_LEN];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               slot_reg, slot_next;
    logic [CNT_W-1:0]   len_a_reg, len_b_reg;
    logic               stored_a_reg, stored_b_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   widx_reg;
    logic               pend_reg;
    logic               match_a_reg, match_b_reg;
    logic [DIGIT_W-1:0] e_rd_reg, a_rd_reg, b_rd_reg, a_def_reg, b_def_reg;
    kcl_out_t           result_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [DIGIT_W-1:0] a_digit, b_digit;
    logic               issue;
    logic               write_a, write_b;

    assign rd_addr = idx_reg[IDX_W-1:0];
    assign wr_addr = widx_reg[IDX_W-1:0];
    assign issue   = cmd.walk && (idx_reg != count_reg);
    assign a_digit = stored_a_reg ? a_rd_reg : a_def_reg;
    assign b_digit = stored_b_reg ? b_rd_reg : b_def_reg;
    assign write_a = cmd.walk && cmd.walk_copy && pend_reg && !slot_reg;
    assign write_b = cmd.walk && cmd.walk_copy && pend_reg && slot_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.unlock_fin || cmd.store_fin)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.unlock_fin)
        begin
            if (match_a_reg)
            begin
                slot_next = 1'b0;
            end
            else if (match_b_reg)
            begin
                slot_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            entry_mem[count_reg[IDX_W-1:0]] <= key_value;
        end
        e_rd_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (write_a)
        begin
            code_a_mem[wr_addr] <= e_rd_reg;
        end
        a_rd_reg <= code_a_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (write_b)
        begin
            code_b_mem[wr_addr] <= e_rd_reg;
        end
        b_rd_reg <= code_b_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        a_def_reg <= default_a_digit(LEN_W'(idx_reg));
        b_def_reg <= default_b_digit(LEN_W'(idx_reg));
        widx_reg  <= idx_reg;
        if (cmd.emit)
        begin
            result_reg.status       <= cmd.status;
            result_reg.code_slot    <= slot_next;
            result_reg.entry_length <= LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            slot_reg     <= 1'b0;
            len_a_reg    <= A_RST_LEN;
            len_b_reg    <= B_RST_LEN;
            stored_a_reg <= 1'b0;
            stored_b_reg <= 1'b0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            match_a_reg  <= 1'b0;
            match_b_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            slot_reg  <= slot_next;
            if (cmd.walk_init)
            begin
                idx_reg     <= '0;
                pend_reg    <= 1'b0;
                match_a_reg <= (len_a_reg == count_reg);
                match_b_reg <= (len_b_reg == count_reg);
            end
            else if (cmd.walk)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (pend_reg && !cmd.walk_copy)
                begin
                    match_a_reg <= match_a_reg && (a_digit == e_rd_reg);
                    match_b_reg <= match_b_reg && (b_digit == e_rd_reg);
                end
            end
            if (cmd.store_fin)
            begin
                if (slot_reg)
                begin
                    len_b_reg    <= count_reg;
                    stored_b_reg <= 1'b1;
                end
                else
                begin
                    len_a_reg    <= count_reg;
                    stored_a_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.full     = (count_reg == MAX_CNT);
    assign sts.walk_end = (idx_reg == count_reg) && !pend_reg;
    assign sts.match_a  = match_a_reg;
    assign sts.match_b  = match_b_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count beyond buffer depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> idx_reg <= count_reg)
        else $error("walk index ran past entry count");

    a_deny_keeps_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.unlock_fin && !match_a_reg && !match_b_reg) |=> $stable(slot_reg))
        else $error("slot changed on denied unlock");

endmodule

`default_nettype wire

// ===== src/kcl_ctrl.sv =====
// Controller of the keypad code lock: key decode, compare and copy sequencing, done strobe.
`default_nettype none

module kcl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire kcl_pkg::kcl_in_t  item,
    input  wire kcl_pkg::kcl_sts_t sts,
    output kcl_pkg::kcl_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import kcl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_IGNORED;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.op)
                        OP_DIGIT:
                        begin
                            cmd.push   = !sts.full;
                            cmd.emit   = 1'b1;
                            cmd.status = sts.full ? ST_FULL : ST_DIGIT;
                        end
                        OP_UNLOCK:
                        begin
                            if (item.door_switch)
                            begin
                                cmd.walk_init = 1'b1;
                                state_next    = S_CMP;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                            end
                        end
                        OP_STORE:
                        begin
                            if (!item.door_switch)
                            begin
                                cmd.walk_init = 1'b1;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_end)
                begin
                    cmd.unlock_fin = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.status     = (sts.match_a || sts.match_b) ? ST_GRANTED : ST_DENIED;
                    state_next     = S_IDLE;
                end
            end
            S_COPY:
            begin
                cmd.walk      = 1'b1;
                cmd.walk_copy = 1'b1;
                if (sts.walk_end)
                begin
                    cmd.store_fin = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.status    = ST_STORED;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_unlock_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && item.op == OP_UNLOCK && item.door_switch) |=> (busy && !done))
        else $error("unlock with door switch set did not start a compare");

    a_walk_emits_once: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && cmd.emit) |=> (!busy && done))
        else $error("walk finish did not return to idle with a result");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for keypad_code_lock: directed and random key beats checked against an in-bench lock model.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int MAX_LEN   = 32;
    localparam int KEY_GOAL  = 1850;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        kcl_in_t beat;
        bit      drain;
    } key_req_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    kcl_in_t  item  = '0;
    logic     busy;
    logic     done;
    kcl_out_t result;

    key_req_t key_q[$];
    kcl_out_t status_q[$];
    kcl_out_t head;
    int       beats_sent   = 0;
    int       results_seen = 0;
    int       err_cnt      = 0;
    int       key_cnt      = 0;
    int       gap_left     = 0;
    bit       calm         = 1'b0;
    bit       drain_next   = 1'b0;

    // lock model state
    logic [DIGIT_W-1:0] entry_mem [MAX_LEN];
    logic [LEN_W-1:0]   entry_len;
    logic [DIGIT_W-1:0] code_mem [2][MAX_LEN];
    logic [LEN_W-1:0]   code_len [2];
    logic               matched;

    keypad_code_lock #(
        .MAX_CODE_LEN(MAX_LEN)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit same_code(input int s);
        bit hit;
        int k;
        hit = (code_len[s] == entry_len);
        for (k = 0; k < MAX_LEN; k++)
        begin
            if (hit && k < int'(entry_len) && code_mem[s][k] != entry_mem[k])
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic kcl_out_t lock_step(input kcl_in_t k);
        kcl_out_t r;
        int       i;
        r.status = ST_IGNORED;
        case (k.op)
            OP_DIGIT:
            begin
                if (int'(entry_len) >= MAX_LEN)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    entry_mem[entry_len] = k.key_value;
                    entry_len = entry_len + 1'b1;
                    r.status = ST_DIGIT;
                end
            end
            OP_UNLOCK:
            begin
                if (k.door_switch)
                begin
                    if (same_code(0))
                    begin
                        matched = 1'b0;
                        r.status = ST_GRANTED;
                    end
                    else if (same_code(1))
                    begin
                        matched = 1'b1;
                        r.status = ST_GRANTED;
                    end
                    else
                    begin
                        r.status = ST_DENIED;
                    end
                    entry_len = '0;
                end
            end
            OP_STORE:
            begin
                if (!k.door_switch)
                begin
                    for (i = 0; i < MAX_LEN; i++)
                    begin
                        if (i < int'(entry_len))
                        begin
                            code_mem[matched][i] = entry_mem[i];
                        end
                    end
                    code_len[matched] = entry_len;
                    entry_len = '0;
                    r.status = ST_STORED;
                end
            end
            default:
            begin
            end
        endcase
        r.code_slot    = matched;
        r.entry_length = entry_len;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // driver: one beat per start && !busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                status_q.push_back(lock_step(item));
                beats_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (key_q.size() > 0 && !(key_q[0].drain && results_seen != beats_sent))
                begin
                    item  <= key_q[0].beat;
                    start <= 1'b1;
                    key_q.delete(0);
                    gap_left = pick_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (status_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                begin
                    $display("unexpected result beat: status %0d slot %0d len %0d",
                             result.status, result.code_slot, result.entry_length);
                end
            end
            else
            begin
                head = status_q.pop_front();
                if (result.status !== head.status || result.code_slot !== head.code_slot ||
                    result.entry_length !== head.entry_length)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                    begin
                        $display("result %0d: expected status %0d slot %0d len %0d, got %0d %0d %0d",
                                 results_seen, head.status, head.code_slot, head.entry_length,
                                 result.status, result.code_slot, result.entry_length);
                    end
                end
            end
        end
    end

    task automatic push_key(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] val,
                            input logic sw);
        key_req_t r;
        r.beat.op          = op;
        r.beat.key_value   = val;
        r.beat.door_switch = sw;
        r.drain            = drain_next;
        drain_next         = 1'b0;
        key_q.push_back(r);
        key_cnt++;
    endtask

    task automatic push_noise();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
        begin
            push_key(OP_FUNC, DIGIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
        else if (r == 1)
        begin
            push_key(OP_UNLOCK, DIGIT_W'($urandom_range(0, 15)), 1'b0);
        end
        else
        begin
            push_key(OP_STORE, DIGIT_W'($urandom_range(0, 15)), 1'b1);
        end
    endtask

    task automatic enter_digit(input logic [DIGIT_W-1:0] d);
        if ($urandom_range(0, 99) < 8)
        begin
            push_noise();
        end
        push_key(OP_DIGIT, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic enter_digits(input int n);
        repeat (n)
        begin
            enter_digit(DIGIT_W'($urandom_range(0, 15)));
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(9, MAX_LEN);
    endfunction

    // all queued beats accepted and folded into the model
    task automatic sync_idle();
        do
        begin
            @(negedge clk);
        end
        while (key_q.size() != 0 || start);
    endtask

    initial
    begin : stim
        int seq;
        int kind;
        int s;
        int n;
        int m;
        int flip;
        int k;
        logic [DIGIT_W-1:0] d;

        entry_len = '0;
        matched   = 1'b0;
        for (k = 0; k < MAX_LEN; k++)
        begin
            entry_mem[k]   = '0;
            code_mem[0][k] = (k < 9) ? DIGIT_W'(9 - k) : '0;
            code_mem[1][k] = (k < 3) ? DIGIT_W'(k + 1) : '0;
        end
        code_len[0] = LEN_W'(9);
        code_len[1] = LEN_W'(3);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: factory codes, ignored keys, extreme digits, empty code
        push_key(OP_UNLOCK, 4'd0, 1'b1);
        for (k = 1; k <= 3; k++)
        begin
            push_key(OP_DIGIT, DIGIT_W'(k), 1'b0);
        end
        push_key(OP_UNLOCK, 4'd15, 1'b1);
        for (k = 9; k >= 1; k--)
        begin
            push_key(OP_DIGIT, DIGIT_W'(k), 1'b1);
        end
        push_key(OP_UNLOCK, 4'd0, 1'b1);
        push_key(OP_DIGIT, 4'd15, 1'b1);
        push_key(OP_DIGIT, 4'd0, 1'b0);
        push_key(OP_STORE, 4'd15, 1'b1);
        push_key(OP_UNLOCK, 4'd0, 1'b0);
        push_key(OP_FUNC, 4'd0, 1'b0);
        push_key(OP_FUNC, 4'd15, 1'b1);
        push_key(OP_STORE, 4'd0, 1'b0);
        push_key(OP_DIGIT, 4'd15, 1'b0);
        push_key(OP_DIGIT, 4'd0, 1'b1);
        push_key(OP_UNLOCK, 4'd0, 1'b1);
        push_key(OP_STORE, 4'd0, 1'b0);
        push_key(OP_UNLOCK, 4'd0, 1'b1);

        seq = 0;
        while (key_cnt < KEY_GOAL)
        begin
            sync_idle();
            calm       = ($urandom_range(0, 3) == 0);
            drain_next = (seq == 0) || ($urandom_range(0, 29) == 0);
            kind       = (seq == 0) ? 60 : $urandom_range(0, 99);
            s          = $urandom_range(0, 1);
            n          = int'(code_len[s]);
            if (kind < 35)
            begin
                for (k = 0; k < n; k++)
                begin
                    enter_digit(code_mem[s][k]);
                end
                push_key(OP_UNLOCK, DIGIT_W'($urandom_range(0, 15)), 1'b1);
                if ($urandom_range(0, 1))
                begin
                    enter_digits(pick_len());
                    push_key(OP_STORE, DIGIT_W'($urandom_range(0, 15)), 1'b0);
                end
            end
            else if (kind < 55)
            begin
                // near miss: one digit off, one too many or one too few
                m    = $urandom_range(0, 2);
                flip = (n > 0) ? $urandom_range(0, n - 1) : 0;
                for (k = 0; k < n; k++)
                begin
                    d = code_mem[s][k];
                    if (m == 0 && k == flip)
                    begin
                        d = d + DIGIT_W'($urandom_range(1, 15));
                    end
                    if (!(m == 2 && k == n - 1))
                    begin
                        enter_digit(d);
                    end
                end
                if (m == 1)
                begin
                    enter_digit(DIGIT_W'($urandom_range(0, 15)));
                end
                push_key(OP_UNLOCK, DIGIT_W'($urandom_range(0, 15)), 1'b1);
            end
            else if (kind < 65)
            begin
                // fill past the end of the entry buffer
                enter_digits(MAX_LEN + $urandom_range(1, 3));
                if ($urandom_range(0, 1))
                begin
                    push_key(OP_UNLOCK, DIGIT_W'($urandom_range(0, 15)), 1'b1);
                end
                else
                begin
                    push_key(OP_STORE, DIGIT_W'($urandom_range(0, 15)), 1'b0);
                end
            end
            else if (kind < 80)
            begin
                enter_digits($urandom_range(0, 12));
                push_key(OP_UNLOCK, DIGIT_W'($urandom_range(0, 15)), 1'b1);
            end
            else if (kind < 90)
            begin
                enter_digits(pick_len());
                push_key(OP_STORE, DIGIT_W'($urandom_range(0, 15)), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_key(OP_W'($urandom_range(0, 3)), DIGIT_W'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)));
                end
            end
            seq++;
        end

        sync_idle();
        while (results_seen != beats_sent)
        begin
            @(negedge clk);
        end
        repeat (MAX_LEN + 8) @(negedge clk);
        if (err_cnt == 0 && status_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
